[hdl/pcsp_pkg.sv]
// shared types, constants and compare functions for the pitch-class set prime form block
package pcsp_pkg;

	localparam int PcCount = 12;
	localparam int LvlWidth = 4;

	typedef logic [PcCount-1:0] pc_mask_t;

	// one candidate rotation: present flag and transposed mask
	typedef struct packed {
		logic     vld;
		pc_mask_t mask;
	} cand_t;

	// inversion: class p moves to (12 - p) mod 12
	function automatic pc_mask_t invert_mask(pc_mask_t m);
		pc_mask_t r;
		r[0] = m[0];
		for (int k = 1; k < PcCount; k++) begin
			r[k] = m[PcCount-k];
		end
		return r;
	endfunction

	// index of the highest set bit, zero for an empty mask
	function automatic logic [LvlWidth-1:0] top_bit(pc_mask_t m);
		logic [LvlWidth-1:0] h;
		h = '0;
		for (int i = 0; i < PcCount; i++) begin
			if (m[i]) begin
				h = LvlWidth'(i);
			end
		end
		return h;
	endfunction

	// a strictly more compact than b: smaller span, else lowest differing class in a
	function automatic logic more_compact(pc_mask_t a, pc_mask_t b);
		logic [LvlWidth-1:0] ha;
		logic [LvlWidth-1:0] hb;
		pc_mask_t            d;
		pc_mask_t            low;
		ha  = top_bit(a);
		hb  = top_bit(b);
		d   = a ^ b;
		low = d & (~d + pc_mask_t'(1));
		if (ha != hb) begin
			return ha < hb;
		end
		return |(a & low);
	endfunction

	// keep the earlier candidate unless it is absent or the later one is strictly more compact
	function automatic cand_t pick(cand_t a, cand_t b);
		if (!a.vld) begin
			return b;
		end
		if (b.vld && more_compact(b.mask, a.mask)) begin
			return b;
		end
		return a;
	endfunction

endpackage

[hdl/pitch_class_set_prime_form.sv]
// pitch-class set prime form, with one set in flight;
// the next set is taken the cycle after the result transfer
// the depth is set by the lane register, the merge tree register and the result register
// reset clears the stage valid flags only; data registers are not reset
module pitch_class_set_prime_form (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    set_valid,
	output logic                    set_stall,
	input  logic [11:0]             pitch_set,
	output logic                    form_valid,
	input  logic                    form_stall,
	output logic [11:0]             prime_set,
	output logic [11:0]             original_form,
	output logic [11:0]             inverted_form,
	output logic [3:0]              set_size,
	output logic                    inversion_chosen
);

	logic                                     set_xfer;
	logic                                     v_s1;
	logic                                     v_s2;
	pcsp_pkg::pc_mask_t                       inv_set;
	pcsp_pkg::cand_t [pcsp_pkg::PcCount-1:0]  orig_lane;
	pcsp_pkg::cand_t [pcsp_pkg::PcCount-1:0]  inv_lane;
	pcsp_pkg::cand_t [pcsp_pkg::PcCount-1:0]  orig_lane_s1;
	pcsp_pkg::cand_t [pcsp_pkg::PcCount-1:0]  inv_lane_s1;
	logic [3:0]                               size_s1;
	logic [3:0]                               size_s2;
	pcsp_pkg::cand_t                          orig_best;
	pcsp_pkg::cand_t                          inv_best;
	pcsp_pkg::pc_mask_t                       orig_form;
	pcsp_pkg::pc_mask_t                       inv_form;
	logic                                     pick_inv;

	assign set_xfer  = set_valid && !set_stall;
	assign set_stall = v_s1 || v_s2 || form_valid;
	assign inv_set   = pcsp_pkg::invert_mask(pitch_set);

	// one lane per rotation start
	for (genvar r = 0; r < pcsp_pkg::PcCount; r++) begin : g_lane
		pcsp_lane u_lane (
			.set_mask  (pitch_set),
			.inv_mask  (inv_set),
			.rot       (pcsp_pkg::LvlWidth'(r)),
			.orig_cand (orig_lane[r]),
			.inv_cand  (inv_lane[r])
		);
	end

	// lane results and set size
	always_ff @(posedge clk) begin
		if (set_xfer) begin
			orig_lane_s1 <= orig_lane;
			inv_lane_s1  <= inv_lane;
			size_s1      <= 4'($countones(pitch_set));
		end
		if (v_s1) begin
			size_s2 <= size_s1;
		end
	end

	// merge trees for the original and the inverted set
	pcsp_merge u_merge_orig (
		.clk   (clk),
		.cands (orig_lane_s1),
		.best  (orig_best)
	);

	pcsp_merge u_merge_inv (
		.clk   (clk),
		.cands (inv_lane_s1),
		.best  (inv_best)
	);

	// final choice between the two normal forms
	always_comb begin
		orig_form = orig_best.vld ? orig_best.mask : '0;
		inv_form  = inv_best.vld ? inv_best.mask : '0;
		pick_inv  = pcsp_pkg::more_compact(inv_form, orig_form);
	end

	// stage valid flags and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			form_valid <= 1'b0;
		end else begin
			v_s1 <= set_xfer;
			v_s2 <= v_s1;
			if (v_s2) begin
				form_valid <= 1'b1;
			end else if (!form_stall) begin
				form_valid <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (v_s2) begin
			prime_set        <= pick_inv ? inv_form : orig_form;
			original_form    <= orig_form;
			inverted_form    <= inv_form;
			set_size         <= size_s2;
			inversion_chosen <= pick_inv;
		end
	end

endmodule

[hdl/pcsp_lane.sv]
// one rotation lane: transposes the original and inverted sets to start at class rot
module pcsp_lane (
	input  pcsp_pkg::pc_mask_t                  set_mask,
	input  pcsp_pkg::pc_mask_t                  inv_mask,
	input  logic [pcsp_pkg::LvlWidth-1:0]       rot,
	output pcsp_pkg::cand_t                     orig_cand,
	output pcsp_pkg::cand_t                     inv_cand
);

	logic [2*pcsp_pkg::PcCount-1:0] orig_wide;
	logic [2*pcsp_pkg::PcCount-1:0] inv_wide;

	// cyclic shift right by rot brings class rot down to zero
	always_comb begin
		orig_wide = {set_mask, set_mask} >> rot;
		inv_wide  = {inv_mask, inv_mask} >> rot;
		orig_cand.vld  = set_mask[rot];
		orig_cand.mask = orig_wide[pcsp_pkg::PcCount-1:0];
		inv_cand.vld   = inv_mask[rot];
		inv_cand.mask  = inv_wide[pcsp_pkg::PcCount-1:0];
	end

endmodule

[hdl/pcsp_merge.sv]
// merge tree: picks the most compact of twelve lane candidates, registered halfway
module pcsp_merge (
	input  logic                                      clk,
	input  pcsp_pkg::cand_t [pcsp_pkg::PcCount-1:0]   cands,
	output pcsp_pkg::cand_t                           best
);

	pcsp_pkg::cand_t [5:0] lvl1;
	pcsp_pkg::cand_t [2:0] lvl2;
	pcsp_pkg::cand_t [2:0] lvl2_s2;
	pcsp_pkg::cand_t       lvl3;

	// first two levels: twelve down to three
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			lvl1[i] = pcsp_pkg::pick(cands[2*i], cands[2*i+1]);
		end
		for (int i = 0; i < 3; i++) begin
			lvl2[i] = pcsp_pkg::pick(lvl1[2*i], lvl1[2*i+1]);
		end
	end

	// tree register
	always_ff @(posedge clk) begin
		lvl2_s2 <= lvl2;
	end

	// last two levels: three down to one
	always_comb begin
		lvl3 = pcsp_pkg::pick(lvl2_s2[0], lvl2_s2[1]);
		best = pcsp_pkg::pick(lvl3, lvl2_s2[2]);
	end

endmodule

[hdl/pcsp_checker.sv]
// port-level checker for the prime form block, bound to the top level
module pcsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        set_valid,
	input logic        set_stall,
	input logic [11:0] pitch_set,
	input logic        form_valid,
	input logic        form_stall,
	input logic [11:0] prime_set,
	input logic [11:0] original_form,
	input logic [11:0] inverted_form,
	input logic [3:0]  set_size,
	input logic        inversion_chosen
);

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		form_valid && form_stall |=> form_valid && $stable(prime_set))
		else $error("stalled result changed");

	// prime form is whichever normal form was chosen
	a_choice: assert property (@(posedge clk) disable iff (!arst_n)
		form_valid |-> (prime_set == (inversion_chosen ? inverted_form : original_form)))
		else $error("prime form does not match chosen normal form");

	// the prime and inverted forms keep the set size; the prime form starts at class zero unless empty
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		form_valid |-> ($countones(prime_set) == 32'(set_size))
			&& ($countones(inverted_form) == 32'(set_size))
			&& (prime_set[0] == (set_size != 4'd0)))
		else $error("form size mismatch");

	// only one set in flight: a transfer closes the input side
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		set_valid && !set_stall |=> set_stall)
		else $error("second set accepted while busy");

	// a set needs at least three classes before the inversion can win
	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		form_valid && inversion_chosen |-> set_size >= 4'd3)
		else $error("inversion chosen for a small set");

endmodule

bind pitch_class_set_prime_form pcsp_checker u_pcsp_checker (.*);
